// ===== rtl/core/stunp_pkg.sv =====
// shared types and constants for the stun binding response parser
package stunp_pkg;

  localparam int unsigned POS_W = 17;
  localparam int unsigned CAP_DEPTH = 20;
  localparam int unsigned CAP_IDX_W = 5;

  localparam logic [POS_W-1:0] HDR_BYTES = 17'd20;
  localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;
  localparam logic [15:0] TYPE_BINDING_RESPONSE = 16'h0101;
  localparam logic [31:0] MAGIC = 32'h2112A442;
  localparam logic [15:0] ATTR_MAPPED = 16'h0001;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
  localparam logic [7:0] FAM_V4 = 8'h01;
  localparam logic [7:0] FAM_V6 = 8'h02;

  localparam logic [2:0] STAT_OK = 3'd0;
  localparam logic [2:0] STAT_SHORT = 3'd1;
  localparam logic [2:0] STAT_TYPE = 3'd2;
  localparam logic [2:0] STAT_COOKIE = 3'd3;
  localparam logic [2:0] STAT_TRUNC = 3'd4;
  localparam logic [2:0] STAT_NO_ADDR = 3'd5;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [15:0]      typ;
    logic [15:0]      len;
    logic [31:0]      cookie;
    logic [31:0]      txn_hi;
    logic [63:0]      txn_lo;
  } hdr_st_t;

  typedef struct packed {
    logic        found;
    logic        family;
    logic [15:0] port;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } addr_st_t;

endpackage

// ===== rtl/core/stunp_hdr.sv =====
// byte position counter and stun header capture
module stunp_hdr (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              last,
  input  logic [7:0]        byte_value,
  output stunp_pkg::hdr_st_t cur,
  output stunp_pkg::hdr_st_t upd
);
  import stunp_pkg::*;

  hdr_st_t hdr_r;
  hdr_st_t hdr_nxt;

  always_comb begin
    upd = hdr_r;
    if (hdr_r.pos < 17'd2) begin
      upd.typ = {hdr_r.typ[7:0], byte_value};
    end else if (hdr_r.pos < 17'd4) begin
      upd.len = {hdr_r.len[7:0], byte_value};
    end else if (hdr_r.pos < 17'd8) begin
      upd.cookie = {hdr_r.cookie[23:0], byte_value};
    end else if (hdr_r.pos < 17'd12) begin
      upd.txn_hi = {hdr_r.txn_hi[23:0], byte_value};
    end else if (hdr_r.pos < HDR_BYTES) begin
      upd.txn_lo = {hdr_r.txn_lo[55:0], byte_value};
    end
    upd.pos = (hdr_r.pos < POS_MAX) ? hdr_r.pos + 17'd1 : POS_MAX;
  end

  always_comb begin
    hdr_nxt = hdr_r;
    if (accept) begin
      hdr_nxt = last ? '0 : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= '0;
    end else begin
      hdr_r <= hdr_nxt;
    end
  end

  assign cur = hdr_r;

endmodule

// ===== rtl/core/stunp_walk.sv =====
// attribute walker, value capture and mapped address decode
module stunp_walk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               last,
  input  logic [7:0]         byte_value,
  input  stunp_pkg::hdr_st_t hdr,
  output stunp_pkg::addr_st_t upd
);
  import stunp_pkg::*;

  logic [15:0]      kind_r, kind_nxt, kind_upd;
  logic [15:0]      vlen_r, vlen_nxt, vlen_upd;
  logic [POS_W-1:0] seen_r, seen_nxt, seen_upd;
  logic             stop_r, stop_nxt, stop_upd;
  addr_st_t         addr_r, addr_nxt;

  logic [7:0]           cap_r [CAP_DEPTH];
  logic [7:0]           cap_nxt [CAP_DEPTH];
  logic                 cap_we;
  logic [CAP_IDX_W-1:0] cap_idx;

  logic [POS_W-1:0] end_pos;
  logic [POS_W-1:0] room;
  logic [POS_W-1:0] pad;
  logic [POS_W-1:0] vofs;
  logic [POS_W-1:0] seen_inc;
  logic             in_walk;
  logic             do_decode;

  assign end_pos = HDR_BYTES + {1'b0, hdr.len};
  assign room = end_pos - (hdr.pos + 17'd1);
  assign in_walk = !stop_r && (hdr.pos >= HDR_BYTES) && (hdr.pos < end_pos);
  assign vofs = seen_r - 17'd4;
  assign seen_inc = seen_r + 17'd1;

  always_comb begin
    kind_upd = kind_r;
    vlen_upd = vlen_r;
    seen_upd = seen_r;
    stop_upd = stop_r;
    cap_we = 1'b0;
    cap_idx = vofs[CAP_IDX_W-1:0];
    do_decode = 1'b0;
    pad = ({1'b0, vlen_r} + 17'd3) & ~17'd3;
    if (in_walk) begin
      seen_upd = seen_inc;
      if (seen_r < 17'd4) begin
        if (seen_r < 17'd2) begin
          kind_upd = {kind_r[7:0], byte_value};
        end else begin
          vlen_upd = {vlen_r[7:0], byte_value};
        end
        pad = ({1'b0, vlen_upd} + 17'd3) & ~17'd3;
        if (seen_inc == 17'd4) begin
          if (pad > room) begin
            stop_upd = 1'b1;
            seen_upd = '0;
          end else if (pad == '0) begin
            seen_upd = '0;
          end
        end
      end else begin
        cap_we = (vofs < 17'(CAP_DEPTH));
        if ((seen_inc - 17'd4) >= pad) begin
          do_decode = 1'b1;
          seen_upd = '0;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAP_DEPTH; i++) begin
      cap_nxt[i] = cap_r[i];
    end
    if (cap_we) begin
      cap_nxt[cap_idx] = byte_value;
    end
  end

  always_comb begin
    upd = addr_r;
    if (do_decode && vlen_upd >= 16'd8) begin
      if (kind_upd == ATTR_XOR_MAPPED) begin
        upd.port = {cap_nxt[2], cap_nxt[3]} ^ MAGIC[31:16];
        if (cap_nxt[1] == FAM_V4) begin
          upd.addr_hi = '0;
          upd.addr_lo = {32'd0, {cap_nxt[4], cap_nxt[5], cap_nxt[6], cap_nxt[7]} ^ MAGIC};
          upd.family = 1'b0;
          upd.found = 1'b1;
        end else if (cap_nxt[1] == FAM_V6 && vlen_upd >= 16'd20) begin
          upd.addr_hi = {cap_nxt[4], cap_nxt[5], cap_nxt[6], cap_nxt[7],
                         cap_nxt[8], cap_nxt[9], cap_nxt[10], cap_nxt[11]}
                        ^ {MAGIC, hdr.txn_hi};
          upd.addr_lo = {cap_nxt[12], cap_nxt[13], cap_nxt[14], cap_nxt[15],
                         cap_nxt[16], cap_nxt[17], cap_nxt[18], cap_nxt[19]}
                        ^ hdr.txn_lo;
          upd.family = 1'b1;
          upd.found = 1'b1;
        end
      end else if (kind_upd == ATTR_MAPPED && !addr_r.found) begin
        upd.port = {cap_nxt[2], cap_nxt[3]};
        if (cap_nxt[1] == FAM_V4) begin
          upd.addr_hi = '0;
          upd.addr_lo = {32'd0, cap_nxt[4], cap_nxt[5], cap_nxt[6], cap_nxt[7]};
          upd.family = 1'b0;
          upd.found = 1'b1;
        end
      end
    end
  end

  always_comb begin
    kind_nxt = kind_r;
    vlen_nxt = vlen_r;
    seen_nxt = seen_r;
    stop_nxt = stop_r;
    addr_nxt = addr_r;
    if (accept) begin
      if (last) begin
        kind_nxt = '0;
        vlen_nxt = '0;
        seen_nxt = '0;
        stop_nxt = 1'b0;
        addr_nxt = '0;
      end else begin
        kind_nxt = kind_upd;
        vlen_nxt = vlen_upd;
        seen_nxt = seen_upd;
        stop_nxt = stop_upd;
        addr_nxt = upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= '0;
      vlen_r <= '0;
      seen_r <= '0;
      stop_r <= 1'b0;
      addr_r <= '0;
    end else begin
      kind_r <= kind_nxt;
      vlen_r <= vlen_nxt;
      seen_r <= seen_nxt;
      stop_r <= stop_nxt;
      addr_r <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cap_we) begin
      cap_r[cap_idx] <= byte_value;
    end
  end

endmodule

// ===== rtl/core/stun_binding_response_parser.sv =====
// Parses a STUN binding response arriving one byte per word and reports the
// mapped address. One byte is taken every cycle while in_ready is high; the
// header capture and the attribute walk update their state in the cycle a
// byte is taken, and the word carrying last_byte loads the result register,
// whose word is offered on the next cycle. A result waiting in that register
// does not stop input while out_ready is high; with it full and out_ready low,
// in_ready drops. Parser state returns to its reset value after each final
// byte, so datagrams can follow one another with no gap.
module stun_binding_response_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_family,
  output logic [15:0] out_port,
  output logic [63:0] out_address_high,
  output logic [63:0] out_address_low,
  output logic [31:0] out_txn_high,
  output logic [63:0] out_txn_low
);
  import stunp_pkg::*;

  logic      accept;
  logic      finish;
  hdr_st_t   hdr_cur;
  hdr_st_t   hdr_upd;
  addr_st_t  addr_upd;
  logic [2:0] status;
  logic [POS_W-1:0] end_pos;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  status_r;
  logic        family_r;
  logic [15:0] port_r;
  logic [63:0] addr_hi_r;
  logic [63:0] addr_lo_r;
  logic [31:0] txn_hi_r;
  logic [63:0] txn_lo_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept = in_valid && in_ready;
  assign finish = accept && in_last_byte;

  stunp_hdr u_hdr (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .last       (in_last_byte),
    .byte_value (in_byte_value),
    .cur        (hdr_cur),
    .upd        (hdr_upd)
  );

  stunp_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .last       (in_last_byte),
    .byte_value (in_byte_value),
    .hdr        (hdr_cur),
    .upd        (addr_upd)
  );

  assign end_pos = HDR_BYTES + {1'b0, hdr_upd.len};

  always_comb begin
    if (hdr_upd.pos < HDR_BYTES) begin
      status = STAT_SHORT;
    end else if (hdr_upd.typ != TYPE_BINDING_RESPONSE) begin
      status = STAT_TYPE;
    end else if (hdr_upd.cookie != MAGIC) begin
      status = STAT_COOKIE;
    end else if (hdr_upd.pos < end_pos) begin
      status = STAT_TRUNC;
    end else if (!addr_upd.found) begin
      status = STAT_NO_ADDR;
    end else begin
      status = STAT_OK;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status_r <= status;
      family_r <= (status == STAT_OK) ? addr_upd.family : 1'b0;
      port_r <= (status == STAT_OK) ? addr_upd.port : 16'd0;
      addr_hi_r <= (status == STAT_OK) ? addr_upd.addr_hi : 64'd0;
      addr_lo_r <= (status == STAT_OK) ? addr_upd.addr_lo : 64'd0;
      txn_hi_r <= (status == STAT_SHORT) ? 32'd0 : hdr_upd.txn_hi;
      txn_lo_r <= (status == STAT_SHORT) ? 64'd0 : hdr_upd.txn_lo;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_family = family_r;
  assign out_port = port_r;
  assign out_address_high = addr_hi_r;
  assign out_address_low = addr_lo_r;
  assign out_txn_high = txn_hi_r;
  assign out_txn_low = txn_lo_r;

`ifndef NO_ASSERTIONS
  a_finish_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r)
    else $error("final byte did not load a result");

  a_finish_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> hdr_cur.pos == '0)
    else $error("position not cleared after final byte");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != STAT_OK) |->
      (port_r == 16'd0 && addr_hi_r == 64'd0 && addr_lo_r == 64'd0 && !family_r))
    else $error("address fields set on a failed parse");

  a_short_no_txn: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == STAT_SHORT) |-> (txn_hi_r == 32'd0 && txn_lo_r == 64'd0))
    else $error("transaction id set on short header");
`endif

endmodule
